### hw/rtl/gwch_pkg.sv
// Package for the gift-wrap convex hull block: payload types, sequencer states,
// the word field and point ordering functions and the default store depth.
// No dependencies.
package gwch_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_W        = 16;
  localparam int WORD_W         = 2 * COORD_W;

  typedef logic [WORD_W-1:0] point_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      is_final;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hull_x;
    logic signed [COORD_W-1:0] hull_y;
    logic                      end_of_hull;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FS_RD,
    ST_FS_CMP,
    ST_SMALL_A,
    ST_SMALL_B,
    ST_SC_RD,
    ST_SC_LOAD,
    ST_SC_MUL1,
    ST_SC_MUL2,
    ST_SC_CMP,
    ST_EMIT
  } state_t;

  // A stored word keeps x in the low half and y in the high half.
  function automatic logic signed [COORD_W-1:0] word_x(input point_word_t w);
    word_x = w[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] word_y(input point_word_t w);
    word_y = w[WORD_W-1:COORD_W];
  endfunction

  // True when point a sorts before point b: by x first, then by y.
  function automatic logic point_before(input point_word_t a, input point_word_t b);
    if (word_x(a) != word_x(b)) begin
      point_before = word_x(a) < word_x(b);
    end else begin
      point_before = word_y(a) < word_y(b);
    end
  endfunction

endpackage

### hw/rtl/gwch_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gwch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### hw/rtl/gift_wrap_convex_hull_top.sv
// Gift-wrap (Jarvis march) convex hull over a set of signed 16-bit points.
// Depends on gwch_pkg and on gwch_ram for the point store.
//
// Points come in one word per accepted start, and each is written to the point
// store as it comes, so loading runs at one point per clock while busy stays low.
// Up to MAX_POINTS points are kept; further points of the same set are dropped.
// The word marked is_final is stored as well if there is room, and starts the
// hull: busy rises and stays high until the last hull point is out. The block
// first walks the store to find the start point (least x, then least y),
// reading and then comparing each point in turn. Sets of one or two points
// then go out sorted. Larger sets are wrapped: for each hull point the whole
// store is scanned once through the single read port, and every candidate that
// has to be weighed against the current best one goes through the one shared
// 17 x 17 multiplier twice for the cross product. A point that is skipped or
// taken as the first candidate is read and loaded; a compared point is read,
// loaded, multiplied twice and compared; each hull point is then handed out.
// Collinear candidates are settled by the L1 length of their offsets, which needs
// no multiply. Hull points go out in clockwise order, each on out_data for
// exactly one cycle with out_valid high; the receiver cannot stall them, so it
// must take every word in the cycle that it appears. The last word of a set has
// end_of_hull set, and busy is already low in that cycle.
module gift_wrap_convex_hull_top #(
  parameter int MAX_POINTS = gwch_pkg::MAX_POINTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gwch_pkg::in_t in_data,
  output logic          out_valid,
  output gwch_pkg::out_t out_data
);

  import gwch_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_W + 1;

  // Sequencer and counters.
  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         n_r;
  logic [CW-1:0]         k_r;
  logic [AW-1:0]         idx_r;
  logic                  have_r;

  // Point words and offsets.
  point_word_t           start_w_r;
  point_word_t           cur_w_r;
  point_word_t           cand_w_r;
  point_word_t           w_r;
  logic signed [DW-1:0]  ax_r, ay_r, bx_r, by_r;
  logic signed [2*DW-1:0] prod1_r, prod2_r;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  // Store port.
  logic                  ram_we, ram_re;
  point_word_t           ram_wdata, ram_rdata;

  logic                  accept, store_room, idx_last, emit_done, cand_better;
  logic [CW-1:0]         n_load;
  point_word_t           start_new;
  logic signed [DW-1:0]  rd_dx, rd_dy, mul_a, mul_b;
  logic signed [2*DW-1:0] mul_p;
  logic [DW-1:0]         abs_ax, abs_ay, abs_bx, abs_by;
  logic [DW:0]           l1_a, l1_b;

  gwch_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign store_room = (count_r < CW'(MAX_POINTS));
  assign n_load     = store_room ? count_r + CW'(1) : count_r;
  assign ram_we     = accept && store_room;
  assign ram_wdata  = {in_data.point_y, in_data.point_x};
  assign idx_last   = ((CW'(idx_r) + CW'(1)) == n_r);

  // The start point is the least one by x, then y.
  assign start_new = ((idx_r == '0) || point_before(ram_rdata, start_w_r)) ?
                     ram_rdata : start_w_r;

  // Offsets of the word just read from the current hull point.
  assign rd_dx = DW'(word_x(ram_rdata)) - DW'(word_x(cur_w_r));
  assign rd_dy = DW'(word_y(ram_rdata)) - DW'(word_y(cur_w_r));

  // The shared multiplier forms ax*by, then ay*bx.
  assign mul_a = (state_r == ST_SC_MUL1) ? ax_r : ay_r;
  assign mul_b = (state_r == ST_SC_MUL1) ? by_r : bx_r;
  assign mul_p = mul_a * mul_b;

  // For collinear offsets, the L1 length orders them as the Euclidean one does.
  assign abs_ax = ax_r[DW-1] ? DW'(-ax_r) : DW'(ax_r);
  assign abs_ay = ay_r[DW-1] ? DW'(-ay_r) : DW'(ay_r);
  assign abs_bx = bx_r[DW-1] ? DW'(-bx_r) : DW'(bx_r);
  assign abs_by = by_r[DW-1] ? DW'(-by_r) : DW'(by_r);
  assign l1_a   = {1'b0, abs_ax} + {1'b0, abs_ay};
  assign l1_b   = {1'b0, abs_bx} + {1'b0, abs_by};

  // The cross product is negative when ax*by < ay*bx.
  assign cand_better = (prod1_r < prod2_r) || ((prod1_r == prod2_r) && (l1_a > l1_b));

  assign emit_done = !have_r || (cand_w_r == start_w_r) ||
                     ((k_r + CW'(1)) >= CW'(MAX_POINTS));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_data.is_final) begin
          state_nxt = ST_FS_RD;
        end
      end
      ST_FS_RD: begin
        state_nxt = ST_FS_CMP;
      end
      ST_FS_CMP: begin
        if (!idx_last) begin
          state_nxt = ST_FS_RD;
        end else if (n_r <= CW'(2)) begin
          state_nxt = ST_SMALL_A;
        end else begin
          state_nxt = ST_SC_RD;
        end
      end
      ST_SMALL_A: begin
        state_nxt = (n_r == CW'(2)) ? ST_SMALL_B : ST_IDLE;
      end
      ST_SMALL_B: begin
        state_nxt = ST_IDLE;
      end
      ST_SC_RD: begin
        state_nxt = ST_SC_LOAD;
      end
      ST_SC_LOAD: begin
        if ((ram_rdata != cur_w_r) && have_r) begin
          state_nxt = ST_SC_MUL1;
        end else begin
          state_nxt = idx_last ? ST_EMIT : ST_SC_RD;
        end
      end
      ST_SC_MUL1: begin
        state_nxt = ST_SC_MUL2;
      end
      ST_SC_MUL2: begin
        state_nxt = ST_SC_CMP;
      end
      ST_SC_CMP: begin
        state_nxt = idx_last ? ST_EMIT : ST_SC_RD;
      end
      ST_EMIT: begin
        state_nxt = emit_done ? ST_IDLE : ST_SC_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: store reads and result words.
  always_comb begin
    ram_re        = 1'b0;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    unique case (state_r)
      ST_FS_RD, ST_SC_RD: begin
        ram_re = 1'b1;
      end
      ST_SMALL_A: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.hull_x      = word_x(start_w_r);
        out_data_nxt.hull_y      = word_y(start_w_r);
        out_data_nxt.end_of_hull = (n_r != CW'(2));
      end
      ST_SMALL_B: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.hull_x      = word_x(cand_w_r);
        out_data_nxt.hull_y      = word_y(cand_w_r);
        out_data_nxt.end_of_hull = 1'b1;
      end
      ST_EMIT: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.hull_x      = word_x(cur_w_r);
        out_data_nxt.hull_y      = word_y(cur_w_r);
        out_data_nxt.end_of_hull = emit_done;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      n_r         <= '0;
      k_r         <= '0;
      idx_r       <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_data.is_final) begin
              n_r     <= n_load;
              count_r <= '0;
              idx_r   <= '0;
            end else begin
              count_r <= n_load;
            end
          end
        end
        ST_FS_CMP: begin
          if (idx_last) begin
            idx_r  <= '0;
            k_r    <= '0;
            have_r <= 1'b0;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        ST_SC_LOAD: begin
          if ((ram_rdata != cur_w_r) && !have_r) begin
            have_r <= 1'b1;
          end
          if (((ram_rdata == cur_w_r) || !have_r) && !idx_last) begin
            idx_r <= idx_r + AW'(1);
          end
        end
        ST_SC_CMP: begin
          if (!idx_last) begin
            idx_r <= idx_r + AW'(1);
          end
        end
        ST_EMIT: begin
          idx_r  <= '0;
          have_r <= 1'b0;
          k_r    <= k_r + CW'(1);
        end
        default: begin
          k_r <= k_r;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    unique case (state_r)
      ST_FS_CMP: begin
        start_w_r <= start_new;
        cur_w_r   <= start_new;
        // For a two-point set the other point is kept as the candidate.
        if (idx_r != '0) begin
          cand_w_r <= point_before(ram_rdata, start_w_r) ? start_w_r : ram_rdata;
        end
      end
      ST_SC_LOAD: begin
        w_r  <= ram_rdata;
        ax_r <= rd_dx;
        ay_r <= rd_dy;
        if ((ram_rdata != cur_w_r) && !have_r) begin
          cand_w_r <= ram_rdata;
          bx_r     <= rd_dx;
          by_r     <= rd_dy;
        end
      end
      ST_SC_MUL1: begin
        prod1_r <= mul_p;
      end
      ST_SC_MUL2: begin
        prod2_r <= mul_p;
      end
      ST_SC_CMP: begin
        if (cand_better) begin
          cand_w_r <= w_r;
          bx_r     <= ax_r;
          by_r     <= ay_r;
        end
      end
      ST_EMIT: begin
        cur_w_r <= cand_w_r;
      end
      default: begin
        w_r <= w_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result word only ever follows one of the emitting states.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_EMIT || $past(state_r) == ST_SMALL_A ||
                     $past(state_r) == ST_SMALL_B))
    else $error("result word without an emitting state");

  // A final word always starts a hull computation.
  a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.is_final) |=> busy)
    else $error("final word did not start the hull");

  // The last word of a set leaves the block ready for the next set.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.end_of_hull) |-> !busy)
    else $error("block still busy after the last hull word");

  // The store never holds more than its depth, and the walk stays bounded.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(MAX_POINTS)) && (k_r <= CW'(MAX_POINTS)))
    else $error("point count or hull length out of range");

endmodule

### bench/tb_gift_wrap_convex_hull_top.sv
// Self-checking bench for gift_wrap_convex_hull_top: point sets go in as command
// words, and every hull word that comes out is checked against a local predictor.
// Depends on gwch_pkg and on the RTL of the block and its point store.
`timescale 1ns / 100ps

module tb_gift_wrap_convex_hull_top;

  import gwch_pkg::*;

  localparam int STORE_DEPTH  = MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 390;
  // Longest wait, in clocks, for the last hull words once all points are in. It
  // is several times what one full set of 64 hull points takes.
  localparam int DRAIN_LIMIT  = 100000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  gift_wrap_convex_hull_top #(
    .MAX_POINTS(STORE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The run is cut off here if the block hangs or stops producing hull words.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Point words still to be sent, and the hull words the predictor has worked out.
  in_t  point_feed_q[$];
  out_t hull_expect_q[$];

  // The predictor's own copy of the point store and its fill level.
  point_word_t set_store[STORE_DEPTH];
  int          set_count = 0;

  int mismatch_count = 0;
  int points_sent    = 0;
  int hull_words     = 0;
  int hulls_done     = 0;

  // Sender pacing: a burst of words is sent back to back, then a gap may follow.
  int burst_left = 0;
  int gap_left   = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint coord_x(point_word_t w);
    return longint'($signed(w[COORD_W-1:0]));
  endfunction

  function automatic longint coord_y(point_word_t w);
    return longint'($signed(w[WORD_W-1:COORD_W]));
  endfunction

  // Lexical order of the points: x first, then y.
  function automatic bit sorts_ahead(point_word_t a, point_word_t b);
    if (coord_x(a) != coord_x(b)) begin
      return coord_x(a) < coord_x(b);
    end
    return coord_y(a) < coord_y(b);
  endfunction

  function automatic void push_hull_word(point_word_t w, bit last);
    out_t r;
    r.hull_x      = w[COORD_W-1:0];
    r.hull_y      = w[WORD_W-1:COORD_W];
    r.end_of_hull = last;
    hull_expect_q.push_back(r);
  endfunction

  // Gift-wrap the stored set and queue the hull words it should produce.
  function automatic void wrap_stored_set();
    int          n;
    int          i;
    int          first;
    int          cur;
    int          cand;
    int          k;
    point_word_t pw;
    point_word_t w;
    longint      cx;
    longint      cy;
    longint      ax;
    longint      ay;
    longint      bx;
    longint      by;
    longint      z;
    bit          have;
    bit          done;
    n = set_count;
    if (n == 0) begin
      return;
    end
    // One or two points simply go out in sorted order.
    if (n == 1) begin
      push_hull_word(set_store[0], 1'b1);
      return;
    end
    if (n == 2) begin
      if (sorts_ahead(set_store[1], set_store[0])) begin
        push_hull_word(set_store[1], 1'b0);
        push_hull_word(set_store[0], 1'b1);
      end else begin
        push_hull_word(set_store[0], 1'b0);
        push_hull_word(set_store[1], 1'b1);
      end
      return;
    end
    // The wrap begins at the lowest point in lexical order.
    first = 0;
    for (i = 1; i < n; i++) begin
      if (sorts_ahead(set_store[i], set_store[first])) begin
        first = i;
      end
    end
    cur = first;
    k   = 0;
    forever begin
      pw   = set_store[cur];
      cx   = coord_x(pw);
      cy   = coord_y(pw);
      have = 1'b0;
      cand = cur;
      for (i = 0; i < n; i++) begin
        w = set_store[i];
        // Copies of the current hull point are never candidates.
        if (w == pw) begin
          continue;
        end
        if (!have) begin
          cand = i;
          have = 1'b1;
          continue;
        end
        ax = coord_x(w) - cx;
        ay = coord_y(w) - cy;
        bx = coord_x(set_store[cand]) - cx;
        by = coord_y(set_store[cand]) - cy;
        z  = ax * by - ay * bx;
        if (z < 0) begin
          cand = i;
        end else if (z == 0 && ax * ax + ay * ay > bx * bx + by * by) begin
          // On a shared ray the farther point wins.
          cand = i;
        end
      end
      done = !have || set_store[cand] == set_store[first] || (k + 1 >= STORE_DEPTH);
      push_hull_word(pw, done);
      k++;
      if (done) begin
        break;
      end
      cur = cand;
    end
  endfunction

  // One accepted word: store the point if there is room, wrap on the final one.
  function automatic void take_point_word(in_t it);
    if (set_count < STORE_DEPTH) begin
      set_store[set_count] = {it.point_y, it.point_x};
      set_count++;
    end
    if (it.is_final) begin
      wrap_stored_set();
      set_count = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // A word is taken at an edge where start is high and busy is low. Once raised,
  // start stays high until the word is taken; while the block wraps a set the
  // word simply waits. Every output gets at most one nonblocking assignment per edge.
  always @(posedge clk) begin
    bit taken;
    if (!rst_n) begin
      start      <= 1'b0;
      in_data    <= '0;
      burst_left = 8;
      gap_left   = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        take_point_word(in_data);
        points_sent++;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          // Start a new burst; about one in four follows with no gap at all.
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      if (start && !taken) begin
        // Hold the pending word until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (point_feed_q.size() > 0) begin
        in_data <= point_feed_q.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------

  // Hull words cannot be held off, so each one is checked in the cycle it is valid.
  always @(posedge clk) begin
    out_t exp_word;
    if (rst_n && out_valid) begin
      if (hull_expect_q.size() == 0) begin
        $error("unexpected hull word: x %0d y %0d end %0b",
               out_data.hull_x, out_data.hull_y, out_data.end_of_hull);
        mismatch_count++;
      end else begin
        exp_word = hull_expect_q.pop_front();
        hull_words++;
        if (out_data.hull_x !== exp_word.hull_x) begin
          $error("hull_x: expected %0d, got %0d", exp_word.hull_x, out_data.hull_x);
          mismatch_count++;
        end
        if (out_data.hull_y !== exp_word.hull_y) begin
          $error("hull_y: expected %0d, got %0d", exp_word.hull_y, out_data.hull_y);
          mismatch_count++;
        end
        if (out_data.end_of_hull !== exp_word.end_of_hull) begin
          $error("end_of_hull: expected %0b, got %0b",
                 exp_word.end_of_hull, out_data.end_of_hull);
          mismatch_count++;
        end
        if (exp_word.end_of_hull) begin
          hulls_done++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_point(int x, int y, bit fin);
    in_t it;
    it.point_x  = x[COORD_W-1:0];
    it.point_y  = y[COORD_W-1:0];
    it.is_final = fin;
    point_feed_q.push_back(it);
  endtask

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // A set of n points whose last one is final. The spread is one of: the full
  // coordinate range, a tiny cluster (lots of duplicates and collinear runs),
  // only extreme values, or points on a parabola, where every point is on the hull.
  task automatic queue_random_set(int n, int spread);
    int i;
    int x;
    int y;
    int cx;
    int cy;
    int t;
    cx = int'($urandom_range(0, 64000)) - 32000;
    cy = int'($urandom_range(0, 64000)) - 32000;
    for (i = 0; i < n; i++) begin
      case (spread)
        0: begin
          x = $urandom;
          y = $urandom;
        end
        1: begin
          x = cx + int'($urandom_range(0, 6)) - 3;
          y = cy + int'($urandom_range(0, 6)) - 3;
        end
        2: begin
          x = extreme_coord();
          y = extreme_coord();
        end
        default: begin
          t = int'($urandom_range(0, 362)) - 181;
          x = t * 150;
          y = t * t - 16384;
        end
      endcase
      queue_point(x, y, i == n - 1);
    end
  endtask

  initial begin
    int random_items;
    int set_no;
    int n;
    int waited;

    // Corners of the coordinate range with a point inside.
    queue_point(-32768, -32768, 1'b0);
    queue_point(32767, 32767, 1'b0);
    queue_point(-32768, 32767, 1'b0);
    queue_point(32767, -32768, 1'b0);
    queue_point(0, 0, 1'b1);
    // A lone point.
    queue_point(-1, -1, 1'b1);
    // Two points given out of order; they share x, so y decides.
    queue_point(5, 9, 1'b0);
    queue_point(5, -9, 1'b1);
    // Every point the same: only the start comes out.
    queue_point(100, -200, 1'b0);
    queue_point(100, -200, 1'b0);
    queue_point(100, -200, 1'b1);
    // All on one line: only the two ends come out.
    queue_point(0, 0, 1'b0);
    queue_point(30000, 30000, 1'b0);
    queue_point(-30000, -30000, 1'b0);
    queue_point(10, 10, 1'b1);
    // A square with a copy of its start and points in the middle of its top and left sides.
    queue_point(-5, -5, 1'b0);
    queue_point(-5, -5, 1'b0);
    queue_point(5, 5, 1'b0);
    queue_point(-5, 5, 1'b0);
    queue_point(5, -5, 1'b0);
    queue_point(0, 5, 1'b0);
    queue_point(-5, 0, 1'b1);

    // Random sets, mostly small. One set fills the store with a large hull and
    // one runs past the store, so its last points, the final one too, are dropped.
    random_items = 0;
    set_no       = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (set_no == 8) begin
        n = STORE_DEPTH;
        queue_random_set(n, 3);
      end else if (set_no == 20) begin
        n = STORE_DEPTH + 4;
        queue_random_set(n, 0);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        queue_random_set(n, $urandom_range(0, 3));
      end
      random_items += n;
      set_no++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every point word to be taken.
    while (point_feed_q.size() > 0 || start) begin
      @(posedge clk);
    end

    // Then for the last hull words, with a bound of its own.
    waited = 0;
    while (hull_expect_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (hull_expect_q.size() > 0) begin
      $error("%0d expected hull words never arrived", hull_expect_q.size());
      mismatch_count++;
    end
    // A short tail to catch stray words after the last hull.
    repeat (50) @(posedge clk);

    $display("Sent %0d point words; checked %0d hull words over %0d hulls.",
             points_sent, hull_words, hulls_done);
    $display("Covered single and paired points, duplicates, collinear runs and an overfull set.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
